FILE: design/ordl_pkg.sv
// shared constants, types and codes for the ordered list core
package ordl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
	localparam int ENTRY_W    = 32;
	localparam int ACTION_W   = 2;
	localparam int POS_W      = 4;
	localparam int STATUS_W   = 2;
	localparam int LENGTH_W   = 5;
	localparam int SEL_W      = 3;

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [SEL_W-1:0] sel_t;

	localparam action_t ACT_FRONT  = 2'd0;
	localparam action_t ACT_BACK   = 2'd1;
	localparam action_t ACT_DELETE = 2'd2;

	localparam status_t STAT_DONE    = 2'd0;
	localparam status_t STAT_FULL    = 2'd1;
	localparam status_t STAT_MISSING = 2'd2;

	localparam sel_t SEL_HOLD  = 3'd0;
	localparam sel_t SEL_LEFT  = 3'd1;
	localparam sel_t SEL_RIGHT = 3'd2;
	localparam sel_t SEL_WRAP  = 3'd3;
	localparam sel_t SEL_VALUE = 3'd4;

	typedef struct packed {
		sel_t   sel;
		entry_t key;
	} ordl_ctl_t;

endpackage

FILE: design/ordl_if.sv
// command and result channel interfaces
interface ordl_cmd_if;
	logic                  valid;
	logic                  ready;
	ordl_pkg::action_t     action;
	ordl_pkg::entry_t      value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface ordl_res_if;
	logic                          valid;
	logic                          ready;
	ordl_pkg::entry_t              entry;
	logic                          entry_valid;
	logic [ordl_pkg::POS_W-1:0]    position;
	ordl_pkg::status_t             status;
	logic [ordl_pkg::LENGTH_W-1:0] length;
	logic                          last;

	modport source (output valid, output entry, output entry_valid, output position,
		output status, output length, output last, input ready);
	modport sink (input valid, input entry, input entry_valid, input position,
		input status, input length, input last, output ready);
endinterface

FILE: design/ordl_cell.sv
// list cell: holds an entry, loads a neighbor, wrap or key, compares with key
module ordl_cell (
	input  logic                clk,
	input  ordl_pkg::ordl_ctl_t ctl,
	input  ordl_pkg::entry_t    key,
	input  ordl_pkg::entry_t    left,
	input  ordl_pkg::entry_t    right,
	input  ordl_pkg::entry_t    wrap,
	output ordl_pkg::entry_t    data,
	output logic                match
);
	import ordl_pkg::*;

	entry_t data_q;

	always_ff @(posedge clk) begin
		case (ctl.sel)
			SEL_LEFT:  data_q <= left;
			SEL_RIGHT: data_q <= right;
			SEL_WRAP:  data_q <= wrap;
			SEL_VALUE: data_q <= ctl.key;
			default:   data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == key);

endmodule

FILE: design/ordered_list_insert_delete_core.sv
// top level: ordered list held in a chain of cells, streamed after every operation
//
//  channel | dir | handshake    | payload
//  cmd     | in  | valid/ready  | action, value
//  res     | out | valid/ready  | entry, entry_valid, position, status, length, last
//
// an operation is applied to the cell chain as it is accepted, then the list is streamed
// by rotating the chain one cell a cycle: max(length, 1) results per item
// cmd.ready is high only between runs; the output register lets a run end
// while its last result still waits. res.ready low holds the rotation once a result waits
// reset empties the list at once; cell contents need no clearing
module ordered_list_insert_delete_core (
	input  logic       clk,
	input  logic       arst_n,
	ordl_cmd_if.sink   cmd,
	ordl_res_if.source res
);
	import ordl_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic      state_q;
	len_t      len_q;
	len_t      cnt_q;
	status_t   stat_q;
	logic      out_valid_q;

	entry_t                  out_entry_q;
	logic                    out_evalid_q;
	logic [POS_W-1:0]        out_pos_q;
	status_t                 out_stat_q;
	logic [LENGTH_W-1:0]     out_len_q;
	logic                    out_last_q;

	entry_t                  cell_data [LIST_DEPTH];
	ordl_ctl_t               ctl [LIST_DEPTH];
	logic [LIST_DEPTH-1:0]   match_raw;
	logic [LIST_DEPTH-1:0]   in_list;
	logic [LIST_DEPTH-1:0]   hit;
	logic [LIST_DEPTH-1:0]   from_hit;

	logic    accept;
	logic    emit;
	logic    rotate;
	logic    full;
	logic    last_d;
	len_t    len_d;
	status_t stat_d;

	genvar g;
	generate
		for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
			entry_t left_w;
			entry_t right_w;
			if (g == 0) begin : g_first
				assign left_w = cmd.value;
			end else begin : g_mid_left
				assign left_w = cell_data[g-1];
			end
			if (g == LIST_DEPTH - 1) begin : g_end
				assign right_w = cell_data[g];
			end else begin : g_mid_right
				assign right_w = cell_data[g+1];
			end
			ordl_cell u_cell (
				.clk   (clk),
				.ctl   (ctl[g]),
				.key   (cmd.value),
				.left  (left_w),
				.right (right_w),
				.wrap  (cell_data[0]),
				.data  (cell_data[g]),
				.match (match_raw[g])
			);
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			in_list[i] = (len_t'(i) < len_q);
		end
	end

	// first match onward: lowest set bit and everything above it
	assign hit      = match_raw & in_list;
	assign from_hit = hit | ~(hit - {{(LIST_DEPTH-1){1'b0}}, 1'b1});

	assign accept = cmd.valid && cmd.ready;
	assign emit   = (state_q == ST_RUN) && (!out_valid_q || res.ready);
	assign rotate = emit && (len_q != '0);
	assign full   = (len_q == len_t'(LIST_DEPTH));
	assign last_d = (len_q == '0) || (cnt_q == len_q - len_t'(1));

	always_comb begin
		len_d  = len_q;
		stat_d = STAT_DONE;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			ctl[i].key = cmd.value;
			ctl[i].sel = SEL_HOLD;
		end
		if (accept) begin
			case (cmd.action)
				ACT_FRONT: begin
					if (full) begin
						stat_d = STAT_FULL;
					end else begin
						for (int i = 0; i < LIST_DEPTH; i++) begin
							ctl[i].sel = SEL_LEFT;
						end
						len_d = len_q + len_t'(1);
					end
				end
				ACT_BACK: begin
					if (full) begin
						stat_d = STAT_FULL;
					end else begin
						for (int i = 0; i < LIST_DEPTH; i++) begin
							if (len_t'(i) == len_q) begin
								ctl[i].sel = SEL_VALUE;
							end
						end
						len_d = len_q + len_t'(1);
					end
				end
				ACT_DELETE: begin
					if (hit == '0) begin
						stat_d = STAT_MISSING;
					end else begin
						for (int i = 0; i < LIST_DEPTH; i++) begin
							if (from_hit[i]) begin
								ctl[i].sel = SEL_RIGHT;
							end
						end
						len_d = len_q - len_t'(1);
					end
				end
				default: begin
					stat_d = STAT_DONE;
				end
			endcase
		end else if (rotate) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (len_t'(i + 1) == len_q) begin
					ctl[i].sel = SEL_WRAP;
				end else if (in_list[i]) begin
					ctl[i].sel = SEL_RIGHT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			stat_q      <= STAT_DONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_RUN;
				len_q   <= len_d;
				cnt_q   <= '0;
				stat_q  <= stat_d;
			end else if (emit) begin
				cnt_q <= cnt_q + len_t'(1);
				if (last_d) begin
					state_q <= ST_IDLE;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_entry_q  <= (len_q == '0) ? '0 : cell_data[0];
			out_evalid_q <= (len_q != '0);
			out_pos_q    <= POS_W'(cnt_q);
			out_stat_q   <= stat_q;
			out_len_q    <= LENGTH_W'(len_q);
			out_last_q   <= last_d;
		end
	end

	assign cmd.ready       = (state_q == ST_IDLE);
	assign res.valid       = out_valid_q;
	assign res.entry       = out_entry_q;
	assign res.entry_valid = out_evalid_q;
	assign res.position    = out_pos_q;
	assign res.status      = out_stat_q;
	assign res.length      = out_len_q;
	assign res.last        = out_last_q;

endmodule

FILE: design/ordl_checker.sv
// port-level checks on the result stream, bound to the top level
module ordl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input ordl_pkg::entry_t              res_entry,
	input logic                          res_entry_valid,
	input logic [ordl_pkg::POS_W-1:0]    res_position,
	input ordl_pkg::status_t             res_status,
	input logic [ordl_pkg::LENGTH_W-1:0] res_length,
	input logic                          res_last
);
	import ordl_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_entry) && $stable(res_last))
		else $error("result changed while stalled");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_entry_valid |-> res_last && res_length == '0 && res_position == '0)
		else $error("empty list result malformed");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_entry_valid |->
			(res_last == (LENGTH_W'(res_position) + LENGTH_W'(1) == res_length)))
		else $error("last flag does not match position and length");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STAT_FULL |-> res_length == LENGTH_W'(LIST_DEPTH))
		else $error("full status with list not full");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last ##1 res_valid |->
			res_position == $past(res_position) + POS_W'(1))
		else $error("positions not consecutive");

endmodule

bind ordered_list_insert_delete_core ordl_checker u_ordl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_entry       (res.entry),
	.res_entry_valid (res.entry_valid),
	.res_position    (res.position),
	.res_status      (res.status),
	.res_length      (res.length),
	.res_last        (res.last)
);
